// ===== rtl/ipv6_text_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// ipv6_text_parser_core_macros.svh
// Assertion helpers shared by the IPv6 text parser RTL.
// ----------------------------------------------------------------------------
`ifndef IPV6_TEXT_PARSER_CORE_MACROS_SVH
`define IPV6_TEXT_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define V6P_ASSERT_NOW(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define V6P_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/v6p_pkg.sv =====
// ----------------------------------------------------------------------------
// v6p_pkg
// Types, phase codes, error codes and character helpers for the IPv6 parser.
// ----------------------------------------------------------------------------
package v6p_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       is_last;
    } v6p_in_t;

    typedef struct packed {
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [3:0]  error_code;
    } v6p_out_t;

    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_LEAD      = 3'd1,
        PH_GROUP     = 3'd2,
        PH_HEX       = 3'd3,
        PH_COLON     = 3'd4,
        PH_OCT_START = 3'd5,
        PH_OCT       = 3'd6
    } v6p_phase_t;

    // Error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_LEAD_COLON  = 4'd1;
    localparam logic [3:0] ERR_TOO_MANY    = 4'd2;
    localparam logic [3:0] ERR_SECOND_GAP  = 4'd3;
    localparam logic [3:0] ERR_EMPTY_DOT   = 4'd4;
    localparam logic [3:0] ERR_TRAIL_COLON = 4'd5;
    localparam logic [3:0] ERR_BAD_CHAR    = 4'd6;
    localparam logic [3:0] ERR_NO_ROOM     = 4'd7;
    localparam logic [3:0] ERR_BAD_BCD     = 4'd8;
    localparam logic [3:0] ERR_OCT_START   = 4'd9;
    localparam logic [3:0] ERR_OCT_RANGE   = 4'd10;
    localparam logic [3:0] ERR_OCT_COUNT   = 4'd11;
    localparam logic [3:0] ERR_SHORT       = 4'd12;

    localparam logic [7:0]  CH_COLON     = 8'h3A;
    localparam logic [7:0]  CH_DOT       = 8'h2E;
    localparam logic [3:0]  GROUP_COUNT  = 4'd8;
    localparam logic [3:0]  QUAD_LIMIT   = 4'd6;
    localparam logic [15:0] BCD_MAX      = 16'h0255;
    localparam logic [3:0]  BCD_DIGIT_MAX = 4'd9;
    localparam logic [11:0] OCTET_MAX    = 12'd255;
    localparam logic [2:0]  DIGITS_MAX   = 3'd4;
    localparam logic [1:0]  LAST_OCTET   = 2'd3;

    // {valid, value} for a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, 4'(c[2:0] + 3'd1) + 4'd8};
        return r;
    endfunction

    // {valid, value} for a decimal digit
    function automatic logic [4:0] dec_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        return r;
    endfunction

endpackage

// ===== rtl/ipv6_text_parser_core.sv =====
// Path: the final character passes through the input register, the parse-state
// snapshot register and the result register before its result shows on out_valid.
// Throughput: one character per cycle; the whole pipeline holds only while a
// finished result waits on out_ready.
// Reset: rst_n clears all control and parse state; the parser returns to start of text.
// ----------------------------------------------------------------------------
// ipv6_text_parser_core
// Parses IPv6 address text one character per transaction into a 128-bit
// address or an error code, including '::' compression and a dotted quad.
// ----------------------------------------------------------------------------
`include "ipv6_text_parser_core_macros.svh"

module ipv6_text_parser_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  v6p_pkg::v6p_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output v6p_pkg::v6p_out_t out_data
);
    import v6p_pkg::*;

    // Pipeline moves as a whole whenever the result register is empty or out_ready is high.
    logic advance;

    // Stage A: input register
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    // Stage B: parse state
    logic [15:0] group_reg  [8];
    logic [15:0] group_next [8];
    logic [3:0]  count_reg, count_next;
    logic [3:0]  gap_reg, gap_next;
    logic [15:0] hex_reg, hex_next;
    logic [2:0]  digits_reg, digits_next;
    logic [7:0]  oct_reg, oct_next;
    logic [1:0]  octnum_reg, octnum_next;
    v6p_phase_t  phase_reg, phase_next;
    logic [3:0]  err_reg, err_next;

    // Snapshot of the final parse state, handed to the finishing stage
    logic        fin_valid_reg;
    logic [15:0] fin_group_reg [8];
    logic [3:0]  fin_count_reg;
    logic [3:0]  fin_gap_reg;
    logic [15:0] fin_hex_reg;
    logic [7:0]  fin_oct_reg;
    logic [1:0]  fin_octnum_reg;
    v6p_phase_t  fin_phase_reg;
    logic [3:0]  fin_err_reg;

    // Stage C: result register
    logic     out_valid_reg;
    v6p_out_t out_data_reg;

    // Character decode
    logic [4:0]  hex_d;
    logic [4:0]  dec_d;
    logic        is_colon;
    logic        is_dot;
    logic        bcd_bad;
    logic [9:0]  bcd_value;
    logic [11:0] oct_sum;
    logic [2:0]  oct_idx;
    logic        group_start;

    // Finishing stage
    logic [15:0] fin_grp_w [8];
    logic [3:0]  fin_cnt_w;
    logic [3:0]  fin_err_w;
    logic [3:0]  ncopy;
    logic [3:0]  base;
    logic [3:0]  src_idx [8];
    logic [15:0] res_grp [8];
    v6p_out_t    result;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // ------------------------------------------------------------------
    // Stage A: capture the character
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            char_reg <= in_data.character;
            last_reg <= in_data.is_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: one parse step on the held character
    // ------------------------------------------------------------------
    assign hex_d    = hex_digit(char_reg);
    assign dec_d    = dec_digit(char_reg);
    assign is_colon = (char_reg == CH_COLON);
    assign is_dot   = (char_reg == CH_DOT);

    // First octet of the quad is written as hex but must read as BCD up to 255.
    assign bcd_bad = (hex_reg > BCD_MAX) || (hex_reg[7:4] > BCD_DIGIT_MAX)
                   || (hex_reg[3:0] > BCD_DIGIT_MAX);
    assign bcd_value = 10'(hex_reg[9:8]) * 10'd100 + 10'(hex_reg[7:4]) * 10'd10
                     + 10'(hex_reg[3:0]);
    assign oct_sum = 12'(oct_reg) * 12'd10 + 12'(dec_d[3:0]);
    // Octets fill group_count and the group after it, high byte first.
    assign oct_idx = count_reg[2:0] + {2'b00, octnum_reg[1]};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            group_next[i] = group_reg[i];
        count_next  = count_reg;
        gap_next    = gap_reg;
        hex_next    = hex_reg;
        digits_next = digits_reg;
        oct_next    = oct_reg;
        octnum_next = octnum_reg;
        phase_next  = phase_reg;
        err_next    = err_reg;
        group_start = 1'b0;

        // Drop every character after the first error.
        if (err_reg == ERR_NONE)
        begin
            unique case (phase_reg) inside
                PH_START:
                begin
                    if (is_colon)
                        phase_next = PH_LEAD;
                    else
                        group_start = 1'b1;
                end
                PH_LEAD:
                begin
                    if (!is_colon)
                        err_next = ERR_LEAD_COLON;
                    else
                    begin
                        group_next[0] = 16'd0;
                        count_next    = 4'd1;
                        gap_next      = 4'd1;
                        phase_next    = PH_GROUP;
                    end
                end
                PH_GROUP, PH_COLON:
                begin
                    group_start = 1'b1;
                end
                PH_HEX:
                begin
                    if (hex_d[4])
                    begin
                        if (digits_reg >= DIGITS_MAX)
                            err_next = ERR_BAD_CHAR;
                        else
                        begin
                            hex_next    = {hex_reg[11:0], hex_d[3:0]};
                            digits_next = digits_reg + 3'd1;
                        end
                    end
                    else if (is_colon)
                    begin
                        group_next[count_reg[2:0]] = hex_reg;
                        count_next = count_reg + 4'd1;
                        phase_next = PH_COLON;
                    end
                    else if (is_dot)
                    begin
                        if (count_reg > QUAD_LIMIT)
                            err_next = ERR_NO_ROOM;
                        else if (bcd_bad)
                            err_next = ERR_BAD_BCD;
                        else
                        begin
                            group_next[count_reg[2:0]][15:8] = bcd_value[7:0];
                            octnum_next = 2'd1;
                            phase_next  = PH_OCT_START;
                        end
                    end
                    else
                        err_next = ERR_BAD_CHAR;
                end
                PH_OCT_START:
                begin
                    if (dec_d[4])
                    begin
                        oct_next   = {4'd0, dec_d[3:0]};
                        phase_next = PH_OCT;
                    end
                    else
                        err_next = ERR_OCT_START;
                end
                PH_OCT:
                begin
                    if (dec_d[4])
                    begin
                        if (oct_sum > OCTET_MAX)
                            err_next = ERR_OCT_RANGE;
                        else
                            oct_next = oct_sum[7:0];
                    end
                    else if (is_dot && octnum_reg < LAST_OCTET)
                    begin
                        if (octnum_reg[0])
                            group_next[oct_idx][7:0] = oct_reg;
                        else
                            group_next[oct_idx][15:8] = oct_reg;
                        octnum_next = octnum_reg + 2'd1;
                        phase_next  = PH_OCT_START;
                    end
                    else
                        err_next = ERR_OCT_COUNT;
                end
                default:
                begin
                    err_next = ERR_BAD_CHAR;
                end
            endcase

            // Start of a group: a second colon opens the gap, a hex digit a value.
            if (group_start)
            begin
                if (count_reg >= GROUP_COUNT)
                    err_next = ERR_TOO_MANY;
                else if (is_colon)
                begin
                    if (gap_reg != 4'd0)
                        err_next = ERR_SECOND_GAP;
                    else
                    begin
                        group_next[count_reg[2:0]] = 16'd0;
                        count_next = count_reg + 4'd1;
                        gap_next   = count_reg + 4'd1;
                        phase_next = PH_GROUP;
                    end
                end
                else if (hex_d[4])
                begin
                    hex_next    = {12'd0, hex_d[3:0]};
                    digits_next = 3'd1;
                    phase_next  = PH_HEX;
                end
                else
                    err_next = is_dot ? ERR_EMPTY_DOT : ERR_BAD_CHAR;
            end
        end
    end

    // Hold on stall; on the final character hand the state on and restart.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                group_reg[i] <= 16'd0;
            count_reg     <= 4'd0;
            gap_reg       <= 4'd0;
            hex_reg       <= 16'd0;
            digits_reg    <= 3'd0;
            oct_reg       <= 8'd0;
            octnum_reg    <= 2'd0;
            phase_reg     <= PH_START;
            err_reg       <= ERR_NONE;
            fin_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            fin_valid_reg <= in_valid_reg && last_reg;
            if (in_valid_reg)
            begin
                if (last_reg)
                begin
                    for (int i = 0; i < 8; i++)
                        group_reg[i] <= 16'd0;
                    count_reg  <= 4'd0;
                    gap_reg    <= 4'd0;
                    hex_reg    <= 16'd0;
                    digits_reg <= 3'd0;
                    oct_reg    <= 8'd0;
                    octnum_reg <= 2'd0;
                    phase_reg  <= PH_START;
                    err_reg    <= ERR_NONE;
                end
                else
                begin
                    for (int i = 0; i < 8; i++)
                        group_reg[i] <= group_next[i];
                    count_reg  <= count_next;
                    gap_reg    <= gap_next;
                    hex_reg    <= hex_next;
                    digits_reg <= digits_next;
                    oct_reg    <= oct_next;
                    octnum_reg <= octnum_next;
                    phase_reg  <= phase_next;
                    err_reg    <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && last_reg)
        begin
            for (int i = 0; i < 8; i++)
                fin_group_reg[i] <= group_next[i];
            fin_count_reg  <= count_next;
            fin_gap_reg    <= gap_next;
            fin_hex_reg    <= hex_next;
            fin_oct_reg    <= oct_next;
            fin_octnum_reg <= octnum_next;
            fin_phase_reg  <= phase_next;
            fin_err_reg    <= err_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: close the open group, check counts, expand the gap
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            fin_grp_w[i] = fin_group_reg[i];
        fin_cnt_w = fin_count_reg;
        fin_err_w = fin_err_reg;

        if (fin_err_reg == ERR_NONE)
        begin
            unique case (fin_phase_reg) inside
                PH_START, PH_LEAD:
                    fin_err_w = ERR_LEAD_COLON;
                PH_COLON:
                    fin_err_w = ERR_TRAIL_COLON;
                PH_OCT_START:
                    fin_err_w = ERR_OCT_START;
                PH_HEX:
                begin
                    fin_grp_w[fin_count_reg[2:0]] = fin_hex_reg;
                    fin_cnt_w = fin_count_reg + 4'd1;
                end
                PH_OCT:
                begin
                    if (fin_octnum_reg != LAST_OCTET)
                        fin_err_w = ERR_OCT_COUNT;
                    else
                    begin
                        fin_grp_w[fin_count_reg[2:0] + 3'd1][7:0] = fin_oct_reg;
                        fin_cnt_w = fin_count_reg + 4'd2;
                    end
                end
                default:
                begin
                end
            endcase

            if (fin_err_w == ERR_NONE)
            begin
                if (fin_gap_reg == 4'd0)
                begin
                    if (fin_cnt_w != GROUP_COUNT)
                        fin_err_w = ERR_SHORT;
                end
                else if (fin_cnt_w > GROUP_COUNT || fin_gap_reg > fin_cnt_w)
                    fin_err_w = ERR_TOO_MANY;
            end
        end
    end

    // Groups after the gap move to the top; the gap itself reads as zero.
    assign ncopy = fin_cnt_w - fin_gap_reg;
    assign base  = GROUP_COUNT - ncopy;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            src_idx[i] = fin_gap_reg + 4'(i) - base;
            if (fin_gap_reg == 4'd0 || 4'(i) < fin_gap_reg)
                res_grp[i] = fin_grp_w[i];
            else if (4'(i) >= base)
                res_grp[i] = fin_grp_w[src_idx[i][2:0]];
            else
                res_grp[i] = 16'd0;
        end
    end

    always_comb
    begin
        result.error_code = fin_err_w;
        if (fin_err_w == ERR_NONE)
        begin
            result.address_high = {res_grp[0], res_grp[1], res_grp[2], res_grp[3]};
            result.address_low  = {res_grp[4], res_grp[5], res_grp[6], res_grp[7]};
        end
        else
        begin
            result.address_high = 64'd0;
            result.address_low  = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && fin_valid_reg)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `V6P_ASSERT_NOW(a_gap_in_range, clk, rst_n, 1'b1, gap_reg <= count_reg,
        "gap position beyond group count")
    `V6P_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1, count_reg <= GROUP_COUNT,
        "group count above eight")
    `V6P_ASSERT_NOW(a_hex_digits, clk, rst_n, phase_reg == PH_HEX,
        digits_reg != 3'd0 && digits_reg <= DIGITS_MAX,
        "hex phase with bad digit count")
    `V6P_ASSERT_NEXT(a_finish_delivers, clk, rst_n, fin_valid_reg && advance,
        out_valid_reg, "finished text did not reach the result register")
    `V6P_ASSERT_NOW(a_error_zero_addr, clk, rst_n,
        out_valid_reg && out_data_reg.error_code != ERR_NONE,
        out_data_reg.address_high == 64'd0 && out_data_reg.address_low == 64'd0,
        "error result with nonzero address")

endmodule

// ===== sim/ipv6_text_parser_core_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv6_text_parser_core_checker
// Watches both channels of the IPv6 text parser, predicts the address or
// error for every text it sees accepted, and compares each result field.
// ----------------------------------------------------------------------------
module ipv6_text_parser_core_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  v6p_pkg::v6p_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  v6p_pkg::v6p_out_t out_data,
    output int                mismatches,
    output int                outstanding
);
    import v6p_pkg::*;

    v6p_out_t    expected_addr_q[$];
    v6p_out_t    want;

    // Parser state mirrored from the block
    logic [15:0] grp [8];
    logic [3:0]  grp_count;
    logic [3:0]  gap_at;
    logic [15:0] hex_acc;
    logic [2:0]  hex_digits;
    logic [8:0]  oct_acc;
    logic [1:0]  oct_index;
    v6p_phase_t  phase;
    logic [3:0]  err;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'(8'("0"));
        if (c >= "a" && c <= "f")
            return int'(c) - int'(8'("a")) + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'(8'("A")) + 10;
        return -1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (mismatches < 50)
            $display("MISMATCH at %0t: %s: got %h, want %h", $time, what, got, exp_val);
        mismatches++;
    endtask

    task automatic clear_parse();
        foreach (grp[i])
            grp[i] = '0;
        grp_count  = '0;
        gap_at     = '0;
        hex_acc    = '0;
        hex_digits = '0;
        oct_acc    = '0;
        oct_index  = '0;
        phase      = PH_START;
        err        = ERR_NONE;
    endtask

    // Even octets go to the high byte of their group, odd ones to the low byte.
    task automatic put_octet(input int k, input int val);
        int idx;
        idx = (int'(grp_count) + (k >> 1)) & 7;
        if ((k & 1) == 0)
            grp[idx][15:8] = val[7:0];
        else
            grp[idx][7:0] = val[7:0];
    endtask

    task automatic open_group(input logic [7:0] c);
        int d;
        d = hex_val(c);
        if (grp_count >= GROUP_COUNT)
            err = ERR_TOO_MANY;
        else if (c == CH_COLON)
        begin
            if (gap_at != 0)
                err = ERR_SECOND_GAP;
            else
            begin
                grp[grp_count[2:0]] = '0;
                grp_count++;
                gap_at = grp_count;
                phase  = PH_GROUP;
            end
        end
        else if (d >= 0)
        begin
            hex_acc    = 16'(d);
            hex_digits = 3'd1;
            phase      = PH_HEX;
        end
        else
            err = (c == CH_DOT) ? ERR_EMPTY_DOT : ERR_BAD_CHAR;
    endtask

    task automatic take_char(input logic [7:0] c);
        int d;
        int v;
        d = hex_val(c);
        case (phase)
            PH_START:
                if (c == CH_COLON)
                    phase = PH_LEAD;
                else
                    open_group(c);
            PH_LEAD:
                if (c != CH_COLON)
                    err = ERR_LEAD_COLON;
                else
                begin
                    grp[0]    = '0;
                    grp_count = 4'd1;
                    gap_at    = 4'd1;
                    phase     = PH_GROUP;
                end
            PH_GROUP, PH_COLON:
                open_group(c);
            PH_HEX:
                if (d >= 0)
                begin
                    if (hex_digits >= DIGITS_MAX)
                        err = ERR_BAD_CHAR;
                    else
                    begin
                        hex_acc = {hex_acc[11:0], d[3:0]};
                        hex_digits++;
                    end
                end
                else if (c == CH_COLON)
                begin
                    grp[grp_count[2:0]] = hex_acc;
                    grp_count++;
                    phase = PH_COLON;
                end
                else if (c == CH_DOT)
                begin
                    if (grp_count > QUAD_LIMIT)
                        err = ERR_NO_ROOM;
                    else if (hex_acc > BCD_MAX || hex_acc[7:4] > BCD_DIGIT_MAX
                             || hex_acc[3:0] > BCD_DIGIT_MAX)
                        err = ERR_BAD_BCD;
                    else
                    begin
                        // first octet: hex digits read back as decimal
                        v = int'(hex_acc[11:8]) * 100 + int'(hex_acc[7:4]) * 10
                            + int'(hex_acc[3:0]);
                        put_octet(0, v);
                        oct_index = 2'd1;
                        phase     = PH_OCT_START;
                    end
                end
                else
                    err = ERR_BAD_CHAR;
            PH_OCT_START:
                if (c >= "0" && c <= "9")
                begin
                    oct_acc = 9'(d);
                    phase   = PH_OCT;
                end
                else
                    err = ERR_OCT_START;
            PH_OCT:
                if (c >= "0" && c <= "9")
                begin
                    v = int'(oct_acc) * 10 + d;
                    if (v > OCTET_MAX)
                        err = ERR_OCT_RANGE;
                    else
                        oct_acc = 9'(v);
                end
                else if (c == CH_DOT && oct_index < LAST_OCTET)
                begin
                    put_octet(oct_index, oct_acc);
                    oct_index++;
                    phase = PH_OCT_START;
                end
                else
                    err = ERR_OCT_COUNT;
            default:
                err = ERR_BAD_CHAR;
        endcase
    endtask

    // End of text: flush the open group or quad, expand the gap, queue the result.
    task automatic close_text();
        logic [15:0] packed_grp [8];
        v6p_out_t    res;
        int          ncopy;
        int          base;
        if (err == ERR_NONE)
        begin
            case (phase)
                PH_START, PH_LEAD:
                    err = ERR_LEAD_COLON;
                PH_COLON:
                    err = ERR_TRAIL_COLON;
                PH_OCT_START:
                    err = ERR_OCT_START;
                PH_HEX:
                begin
                    grp[grp_count[2:0]] = hex_acc;
                    grp_count++;
                end
                PH_OCT:
                    if (oct_index != LAST_OCTET)
                        err = ERR_OCT_COUNT;
                    else
                    begin
                        put_octet(3, oct_acc);
                        grp_count = grp_count + 4'd2;
                    end
                default: ;
            endcase
        end
        if (err == ERR_NONE)
        begin
            if (gap_at == 0)
            begin
                if (grp_count != GROUP_COUNT)
                    err = ERR_SHORT;
            end
            else if (grp_count > GROUP_COUNT || gap_at > grp_count)
                err = ERR_TOO_MANY;
            else
            begin
                ncopy = int'(grp_count) - int'(gap_at);
                base  = 8 - ncopy;
                for (int i = 0; i < 8; i++)
                begin
                    if (i < gap_at)
                        packed_grp[i] = grp[i];
                    else if (i >= base)
                        packed_grp[i] = grp[(int'(gap_at) + i - base) & 7];
                    else
                        packed_grp[i] = '0;
                end
                grp = packed_grp;
            end
        end
        res = '0;
        if (err == ERR_NONE)
        begin
            res.address_high = {grp[0], grp[1], grp[2], grp[3]};
            res.address_low  = {grp[4], grp[5], grp[6], grp[7]};
        end
        res.error_code = err;
        expected_addr_q.push_back(res);
        clear_parse();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_parse();
            expected_addr_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_addr_q.size() == 0)
                    report_mismatch("result with nothing expected",
                                    64'(out_data.error_code), '0);
                else
                begin
                    want = expected_addr_q.pop_front();
                    if (out_data.address_high !== want.address_high)
                        report_mismatch("address_high", out_data.address_high,
                                        want.address_high);
                    if (out_data.address_low !== want.address_low)
                        report_mismatch("address_low", out_data.address_low,
                                        want.address_low);
                    if (out_data.error_code !== want.error_code)
                        report_mismatch("error_code", 64'(out_data.error_code),
                                        64'(want.error_code));
                end
            end
            if (in_valid && in_ready)
            begin
                // drop characters that follow an error
                if (err == ERR_NONE)
                    take_char(in_data.character);
                if (in_data.is_last)
                    close_text();
            end
        end
        outstanding = expected_addr_q.size();
    end

endmodule

// ===== sim/ipv6_text_parser_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv6_text_parser_core_test
// Feeds IPv6 address texts, one character per transaction, into the parser:
// a directed set covering every error kind and the edge forms, then random
// well-formed addresses with some corrupted and some pure noise. Both
// channels idle at random. The checker beside the block predicts and
// compares; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module ipv6_text_parser_core_test;
    import v6p_pkg::*;

    typedef logic [7:0] char_q_t[$];

    localparam int RANDOM_CHARS = 1120;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    v6p_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    v6p_out_t out_data;

    int       mismatches;
    int       outstanding;
    int       sent_chars;
    bit       gaps_on;
    string    hex_chars = "0123456789abcdefABCDEF";

    ipv6_text_parser_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    ipv6_text_parser_core_checker i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hold the gap short most of the time; now and then stall for a long stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One group of hex digits; bias toward the all-zero and all-one extremes.
    function automatic string rand_hex_group();
        string s;
        int    r;
        int    k;
        r = $urandom_range(0, 9);
        if (r == 0)
            return "0";
        if (r == 1)
            return ($urandom_range(0, 1) != 0) ? "ffff" : "FFFF";
        s = "";
        repeat ($urandom_range(1, 4))
        begin
            k = $urandom_range(0, 21);
            s = {s, hex_chars.substr(k, k)};
        end
        return s;
    endfunction

    // Build a well-formed address text: full form, or '::' with a random split,
    // optionally ending in a dotted quad. A few carry one group too many.
    function automatic string rand_address();
        string s;
        bit    quad;
        int    slots;
        int    k;
        int    l;
        int    v;
        quad  = ($urandom_range(0, 3) == 0);
        slots = quad ? 6 : 8;
        s     = "";
        if ($urandom_range(0, 3) == 0)
        begin
            for (int i = 0; i < slots; i++)
                s = {s, (i > 0) ? ":" : "", rand_hex_group()};
            if (quad)
                s = {s, ":"};
        end
        else
        begin
            k = ($urandom_range(0, 9) == 0) ? slots : $urandom_range(0, slots - 1);
            l = $urandom_range(0, k);
            for (int i = 0; i < l; i++)
                s = {s, (i > 0) ? ":" : "", rand_hex_group()};
            s = {s, "::"};
            for (int i = 0; i < k - l; i++)
                s = {s, (i > 0) ? ":" : "", rand_hex_group()};
            if (quad && k > l)
                s = {s, ":"};
        end
        if (quad)
        begin
            // first octet goes through the hex path, so decimal text is valid BCD
            v = $urandom_range(0, 255);
            case ($urandom_range(0, 9))
                0:       s = {s, $sformatf("%04d", v)};
                1:       s = {s, rand_hex_group()};
                2:       s = {s, $sformatf("%0d", $urandom_range(256, 999))};
                default: s = {s, $sformatf("%0d", v)};
            endcase
            for (int i = 0; i < 3; i++)
            begin
                v = ($urandom_range(0, 14) == 0) ? $urandom_range(256, 999)
                                                 : $urandom_range(0, 255);
                s = {s, ".", ($urandom_range(0, 4) == 0) ? $sformatf("%03d", v)
                                                         : $sformatf("%0d", v)};
            end
        end
        return s;
    endfunction

    function automatic char_q_t to_chars(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // Send one text, a transaction per character, is_last on the final one.
    // Valid is raised at a falling edge and held until a rising edge sees ready.
    task automatic send_text(input char_q_t text);
        int gap;
        foreach (text[i])
        begin
            gap = gaps_on ? pick_gap() : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= {text[i], 1'(i == text.size() - 1)};
            do
                @(posedge clk);
            while (!in_ready);
            @(negedge clk);
            sent_chars++;
        end
    endtask

    // Receiver side: runs of ready, some long with no stall at all, broken by
    // stalls of random length.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 6))
                @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        string   directed_texts[$];
        char_q_t text;
        int      r;
        int      pos;
        logic [7:0] noise;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        gaps_on  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: edge forms and at least one text per error kind.
        directed_texts = '{
            "::", "::1", "1::", "0:0:0:0:0:0:0:0",
            "ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff",
            ":1", ":",                        // leading colon alone
            "1:2:3:4:5:6:7:8:9",              // ninth group
            "1::2::3::zzzz",                  // second gap, then ignored text
            "1:.2",                           // dot with no digits
            "1:2:3:4:5:6:7:",                 // trailing single colon
            "12345::", "1:g",                 // fifth digit, bad letter
            "1:2:3:4:5:6:7:1.2.3.4",          // no room for the quad
            "::256.1.1.1", "::1a.1.1.1", "::a0.1.1.1",
            "::1.a.1.1", "::1.2.3.",          // octet not starting with a digit
            "::1.2.3.256",                    // octet out of range
            "::1.2.3", "::1.2.3.4.5",         // wrong octet count
            "1:2:3",                          // short without gap
            "::255.255.255.255", "::0255.001.0.00", "1:2:3:4:5:6:1.2.3.4"
        };
        foreach (directed_texts[i])
            send_text(to_chars(directed_texts[i]));
        // A zero byte is just another bad character.
        text = to_chars("1:");
        text.push_back(8'h00);
        text.push_back(8'("2"));
        send_text(text);

        // Random: mostly well-formed addresses, some corrupted, some pure noise.
        sent_chars = 0;
        while (sent_chars < RANDOM_CHARS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0)
            begin
                text.delete();
                repeat ($urandom_range(1, 12))
                begin
                    r = $urandom_range(0, 3);
                    if (r == 0)
                        text.push_back(CH_COLON);
                    else if (r == 1)
                        text.push_back(CH_DOT);
                    else if (r == 2)
                        text.push_back(8'(hex_chars[$urandom_range(0, 21)]));
                    else
                        text.push_back(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                text  = to_chars(rand_address());
                r     = $urandom_range(0, 99);
                pos   = $urandom_range(0, text.size() - 1);
                noise = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                      : (($urandom_range(0, 1) != 0) ? CH_COLON : CH_DOT);
                // corrupt about a third: replace, insert, drop or truncate
                if (r >= 70 && r < 80)
                    text[pos] = noise;
                else if (r >= 80 && r < 88)
                    text.insert(pos, noise);
                else if (r >= 88 && r < 94 && text.size() > 1)
                    text.delete(pos);
                else if (r >= 94)
                    while (text.size() > pos + 1)
                        void'(text.pop_back());
            end
            send_text(text);
        end

        // Drain: wait for every predicted result, then keep watching for strays.
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
